>>> hdl/vief_pkg.sv
// Shared types and constants for the variable-interval EMA filter.
`default_nettype none

package vief_pkg;

  // Fixed field widths
  localparam int TAU_WIDTH = 24;
  localparam int OUT_WIDTH = 32;
  localparam logic [TAU_WIDTH-1:0] TAU_RESET = 24'd500000;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_ADD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic commit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic primed;
  } status_t;

endpackage

`default_nettype wire

>>> hdl/vief_ctrl.sv
// Controller state machine for the variable-interval EMA filter.
`default_nettype none

module vief_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  vief_pkg::status_t status,
  output vief_pkg::cmd_t    cmd
);
  import vief_pkg::*;

  localparam int CW = $clog2(FRAC_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(FRAC_BITS - 1);

  state_t        state, state_next;
  logic [CW-1:0] step;
  logic          out_blocked;

  assign out_blocked = out_valid && out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && status.primed) state_next = S_DIV;
      end
      S_DIV: begin
        if (step == LAST_STEP) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        if (!out_blocked) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_ADD: begin
        cmd.commit = !out_blocked;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) step <= step + 1'b1;
      else step <= '0;
      // Hold the result until its transfer, then drop it
      if (cmd.commit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/vief_dp.sv
// Datapath: interval, serial weight divider, multiply and state update.
`default_nettype none

module vief_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH   = 32,
  parameter int FRAC_BITS    = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [vief_pkg::TAU_WIDTH-1:0]    cfg_wdata,
  input  wire signed [SAMPLE_WIDTH-1:0]    raw_sample,
  input  wire [TIME_WIDTH-1:0]             timestamp,
  input  vief_pkg::cmd_t                   cmd,
  output vief_pkg::status_t                status,
  output logic signed [vief_pkg::OUT_WIDTH-1:0] filtered_value
);
  import vief_pkg::*;

  localparam int OW  = OUT_WIDTH;
  localparam int DW  = ((TIME_WIDTH > TAU_WIDTH) ? TIME_WIDTH : TAU_WIDTH) + 1;
  localparam int FW  = SAMPLE_WIDTH + FRAC_BITS;
  localparam int XW  = (FW > OW) ? FW : OW;
  localparam int PW  = FRAC_BITS + OW + 3;
  localparam logic signed [XW-1:0] OUT_MAX = {{(XW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [XW-1:0] OUT_MIN = {{(XW-OW+1){1'b1}}, {(OW-1){1'b0}}};
  localparam logic [FRAC_BITS:0]   ALPHA_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [TAU_WIDTH-1:0]     tau;
  logic                     primed;
  logic [TIME_WIDTH-1:0]    last_stamp;
  logic signed [OW-1:0]     prev;
  logic signed [OW-1:0]     target;
  logic [DW-1:0]            den;
  logic [DW-1:0]            rem;
  logic [FRAC_BITS-1:0]     quot;
  logic                     alpha_full;
  logic signed [PW-1:0]     prod;

  logic signed [XW-1:0]     tgt_wide;
  logic signed [OW-1:0]     tgt_sat;
  logic [TIME_WIDTH-1:0]    dt;
  logic [DW:0]              rem_shift;
  logic                     rem_ge;
  logic [FRAC_BITS:0]       alpha;
  logic signed [OW:0]       diff;
  logic signed [PW-1:0]     sum;

  assign status.primed = primed;

  // Scale the sample to fixed point and clamp to the output range
  always_comb begin
    tgt_wide = {{(XW-SAMPLE_WIDTH){raw_sample[SAMPLE_WIDTH-1]}}, raw_sample} <<< FRAC_BITS;
    if (tgt_wide > OUT_MAX) tgt_sat = OUT_MAX[OW-1:0];
    else if (tgt_wide < OUT_MIN) tgt_sat = OUT_MIN[OW-1:0];
    else tgt_sat = tgt_wide[OW-1:0];
  end

  // Elapsed ticks, modulo the timestamp width
  assign dt = timestamp - last_stamp;

  // One restoring division step
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, den};

  // Weight, difference and new state value
  assign alpha = alpha_full ? ALPHA_ONE : {1'b0, quot};
  assign diff  = {target[OW-1], target} - {prev[OW-1], prev};
  assign sum   = {{(PW-OW){prev[OW-1]}}, prev} + (prod >>> FRAC_BITS);

  // Time constant register
  always_ff @(posedge clk) begin
    if (rst) tau <= TAU_RESET;
    else if (cfg_we) tau <= cfg_wdata;
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      last_stamp <= '0;
      prev       <= '0;
    end else begin
      if (cmd.load) begin
        last_stamp <= timestamp;
        primed     <= 1'b1;
        if (!primed) prev <= tgt_sat;
      end
      if (cmd.commit) prev <= sum[OW-1:0];
    end
  end

  // Working registers: divider, product and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target     <= tgt_sat;
      rem        <= DW'(dt);
      den        <= DW'(tau) + DW'(dt);
      quot       <= '0;
      alpha_full <= (tau == '0);
    end
    if (cmd.div_step) begin
      quot <= {quot[FRAC_BITS-2:0], rem_ge};
      if (rem_ge) rem <= DW'(rem_shift - {1'b0, den});
      else rem <= rem_shift[DW-1:0];
    end
    if (cmd.mul) prod <= PW'($signed({1'b0, alpha})) * PW'(diff);
    if (cmd.commit) filtered_value <= sum[OW-1:0];
  end

endmodule

`default_nettype wire

>>> hdl/variable_interval_ema_filter_core.sv
// Top level of the variable-interval EMA filter: controller plus datapath.
//
// Input channel: raw_sample and timestamp move on a transfer (in_valid high,
// in_stall low). Output channel: filtered_value moves on a transfer
// (out_valid high, out_stall low). The user writes the time constant through
// cfg_we / cfg_wdata only while the block is idle; the block does not enforce it.
// The first sample after reset only loads the filter state and gives no
// result. Every later sample gives one result: the serial restoring divider
// forms the weight one quotient bit per cycle, then the multiply step and the
// update step follow, and the update registers the result. The block is idle
// again in the first cycle the result is offered and can take the next sample
// then; it takes no new sample before that.
// The result sits in an output register; a new sample may be taken while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds in its update cycle until the register frees.
// Synchronous reset clears the filter state, the timestamp, the primed flag
// and the output valid, and loads the time constant with 500000 ticks.
`default_nettype none

module variable_interval_ema_filter_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH   = 32,
  parameter int FRAC_BITS    = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire [vief_pkg::TAU_WIDTH-1:0]        cfg_wdata,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [SAMPLE_WIDTH-1:0]        raw_sample,
  input  wire [TIME_WIDTH-1:0]                 timestamp,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [vief_pkg::OUT_WIDTH-1:0] filtered_value
);
  import vief_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the load, divide, multiply and update steps
  vief_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and filter state
  vief_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .raw_sample    (raw_sample),
    .timestamp     (timestamp),
    .cmd           (cmd),
    .status        (status),
    .filtered_value(filtered_value)
  );

endmodule

`default_nettype wire

>>> hdl/vief_chk.sv
// Port-level checker for the variable-interval EMA filter, with its bind.
`default_nettype none

module vief_chk (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] filtered_value
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_value))
    else $error("stalled result changed or dropped");

  // A result is never registered in the cycle right after an input transfer
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after input transfer");

  // A new result comes only from a busy block
  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input side was idle");

endmodule

bind variable_interval_ema_filter_core vief_chk u_vief_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .filtered_value(filtered_value)
);

`default_nettype wire

>>> tb/sv/tb_variable_interval_ema_filter_core.sv
// Self-checking testbench for the variable-interval EMA filter core.
`timescale 1ns / 100ps

module tb_variable_interval_ema_filter_core;
  import vief_pkg::*;

  localparam int FRAC = 16;

  typedef enum {ROW_SAMPLE, ROW_TAU} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [TAU_WIDTH-1:0]  tau;
    logic signed [15:0]    raw;
    logic [31:0]           stamp;
    bit                    typed;
    logic [OUT_WIDTH-1:0]  level;
  } directed_row_t;

  // Directed rows: extremes, equal interval and time constant (weight one half),
  // zero interval, zero denominator, zero and full-scale time constant, wraps
  directed_row_t directed_rows [22] = '{
    '{ROW_SAMPLE, 24'd0,        16'sd0,      32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        16'sd32767,  32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, 24'd0,        -16'sd32768, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, 24'd0,        16'sd32767,  32'd500000,    1'b1, 32'h3FFF_8000},
    '{ROW_SAMPLE, 24'd0,        -16'sd1,     32'd500001,    1'b1, 32'h3FFF_8000},
    '{ROW_SAMPLE, 24'd0,        -16'sd32768, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        16'sd12345,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        -16'sd32768, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_TAU,    24'd0,        16'sd0,      32'h0,         1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        -16'sd32768, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 24'd0,        16'sd32767,  32'h8000_0000, 1'b1, 32'h7FFF_0000},
    '{ROW_SAMPLE, 24'd0,        -16'sd1,     32'hFFFF_FFFF, 1'b1, 32'hFFFF_0000},
    '{ROW_SAMPLE, 24'd0,        16'sd0,      32'h0000_0005, 1'b1, 32'h0000_0000},
    '{ROW_TAU,    24'hFF_FFFF,  16'sd0,      32'h0,         1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        16'sd32767,  32'h0000_0005, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, 24'd0,        16'sd32767,  32'h0100_0004, 1'b1, 32'h3FFF_8000},
    '{ROW_SAMPLE, 24'd0,        -16'sd32768, 32'h0100_0003, 1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        16'sd21845,  32'hAAAA_AAAA, 1'b0, 32'h0},
    '{ROW_TAU,    24'd1,        16'sd0,      32'h0,         1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        -16'sd21846, 32'h5555_5555, 1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        16'sd100,    32'h5555_5556, 1'b0, 32'h0},
    '{ROW_SAMPLE, 24'd0,        16'sd0,      32'h5555_5560, 1'b0, 32'h0}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [TAU_WIDTH-1:0]        cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic signed [15:0]          raw_sample = '0;
  logic [31:0]                 timestamp = '0;
  logic                        out_stall = 1'b0;
  wire                         in_stall;
  wire                         out_valid;
  wire signed [OUT_WIDTH-1:0]  filtered_value;

  // Filter state as the block should hold it
  logic [TAU_WIDTH-1:0]        model_tau = TAU_RESET;
  logic signed [31:0]          model_level = '0;
  bit                          model_primed = 1'b0;
  logic [31:0]                 model_stamp = '0;

  logic [OUT_WIDTH-1:0]        expected_levels [$];
  logic [OUT_WIDTH-1:0]        want_level;
  logic [31:0]                 last_sent = '0;
  int                          errors = 0;
  int                          samples_sent = 0;
  int                          results_seen = 0;
  int                          tau_writes = 0;
  int                          stall_left = 0;
  bit                          quiet = 1'b0;

  variable_interval_ema_filter_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .raw_sample     (raw_sample),
    .timestamp      (timestamp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Weight dt / (tau + dt) as Q1.16, one restoring quotient bit per step
  function automatic logic [16:0] smoothing_weight(logic [TAU_WIDTH-1:0] tau,
                                                   logic [31:0] dt);
    logic [32:0] den;
    logic [33:0] rem;
    logic [16:0] q;
    int          i;
    den = 33'(tau) + 33'(dt);
    rem = 34'(dt);
    q = '0;
    if (rem >= den) return 17'h1_0000;
    for (i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Advance the filter by one sample; the first sample only primes the state
  task automatic ema_advance(input logic signed [15:0] raw, input logic [31:0] stamp,
                             output bit has_level, output logic [31:0] level);
    logic signed [31:0] target;
    logic [31:0]        dt;
    logic [16:0]        alpha;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    target = {raw, 16'h0000};
    dt = stamp - model_stamp;
    model_stamp = stamp;
    has_level = model_primed;
    if (!model_primed) begin
      model_level = target;
      model_primed = 1'b1;
    end else begin
      alpha = smoothing_weight(model_tau, dt);
      diff = 33'(target) - 33'(model_level);
      prod = 51'($signed({1'b0, alpha})) * 51'(diff);
      // bits 47:16 of the product are the floor of the scaled update
      model_level = model_level + prod[47:16];
    end
    level = model_level;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    errors++;
  endtask

  // Offer one sample, hold it until the transfer, then predict its result
  task automatic feed_sample(input logic signed [15:0] raw, input logic [31:0] stamp,
                             input bit typed, input logic [31:0] typed_level);
    bit          has_level;
    logic [31:0] level;
    if (!quiet && $urandom_range(0, 99) < 60) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_sample <= raw;
    timestamp <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    last_sent = stamp;
    ema_advance(raw, stamp, has_level, level);
    if (has_level) expected_levels.push_back(typed ? typed_level : level);
  endtask

  // Drop valid and hold until every expected result has come out
  task automatic settle_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_levels.size() != 0);
  endtask

  // Write the time constant once the block has gone idle
  task automatic set_time_constant(input logic [TAU_WIDTH-1:0] tau);
    settle_outputs();
    repeat (FRAC + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= tau;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_tau = tau;
    tau_writes++;
  endtask

  // Check each result transfer, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", filtered_value));
      end else begin
        want_level = expected_levels.pop_front();
        if (filtered_value !== want_level)
          report_mismatch($sformatf("filtered_value %h, expected %h",
                                    filtered_value, want_level));
      end
    end
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [TAU_WIDTH-1:0] phase_tau [8];
    logic signed [15:0]   corner_raw [4];
    logic signed [15:0]   raw;
    logic [31:0]          dt;
    logic [31:0]          span;
    int                   pick;

    corner_raw = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
    phase_tau = '{24'd500000, 24'd0, 24'hFF_FFFF, 24'd1, 24'd1000,
                  24'd0, 24'd37, 24'd0};
    phase_tau[5] = 24'($urandom_range(0, 24'hFF_FFFF));
    phase_tau[7] = 24'($urandom_range(2, 24'h00_FFFF));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_TAU)
        set_time_constant(directed_rows[r].tau);
      else
        feed_sample(directed_rows[r].raw, directed_rows[r].stamp,
                    directed_rows[r].typed, directed_rows[r].level);
    end

    // Random phases, one time constant each; phase 2 runs with no idling
    for (int p = 0; p < 8; p++) begin
      set_time_constant(phase_tau[p]);
      quiet = (p == 2);
      span = {7'b0, phase_tau[p], 1'b1};
      for (int n = 0; n < 80; n++) begin
        if (p == 4 && n == 40) settle_outputs();
        pick = $urandom_range(0, 99);
        if (pick < 10) dt = 0;
        else if (pick < 30) dt = $urandom_range(1, 64);
        else if (pick < 75) dt = $urandom_range(0, span);
        else dt = $urandom;
        if ($urandom_range(0, 99) < 15) raw = corner_raw[$urandom_range(0, 3)];
        else raw = 16'($urandom);
        feed_sample(raw, last_sent + dt, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    settle_outputs();
    repeat (FRAC + 12) @(posedge clk);

    $display("Covered %0d samples and %0d filtered results over %0d time constant writes,",
             samples_sent, results_seen, tau_writes);
    $display("including zero and full-scale time constants, zero intervals and wraps.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Watchdog expired with %0d results outstanding", expected_levels.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
